@@ sv/hcwa_pkg.sv @@
`default_nettype none

package hcwa_pkg;

   localparam int CNT_W  = 16;
   localparam int AMT_W  = 20;
   localparam int OWN_W  = 6;
   localparam int WRK_W  = 6;
   localparam int SPAN_W = 7;
   localparam int AVL_W  = 6;
   localparam int PROD_W = AMT_W + AVL_W;
   localparam int CSR_W  = 2;

   localparam logic [AMT_W-1:0]  CAP_RESET  = 20'd4096;
   localparam logic [SPAN_W-1:0] SPAN_RESET = 7'd64;

   typedef enum logic [CSR_W-1:0] {
      CSR_PAGE_CAP = 2'd0,
      CSR_SPAN_LIM = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_OFFSET = 2'd0,
      KIND_PLACE  = 2'd1,
      KIND_RECORD = 2'd2,
      KIND_TOTAL  = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CALC,
      ST_MULT,
      ST_OFFSET,
      ST_CLOSE1,
      ST_PLACE,
      ST_SPLIT,
      ST_CLOSE2,
      ST_TOTAL
   } state_type;

   typedef struct packed {
      logic load;
      logic calc;
      logic mult;
      logic offset;
      logic close_rec;
      logic close_drop;
      logic place;
      logic split;
      logic total;
   } cmd_type;

   typedef struct packed {
      logic calc_hot;
      logic hot;
      logic cold;
      logic close1;
      logic endall;
      logic rec_ok;
      logic split_more;
      logic merge_open;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

@@ sv/hcwa_ctrl.sv @@
`default_nettype none

module hcwa_ctrl
   import hcwa_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type st,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CALC;
         end
         ST_CALC: begin
            state_in = st.calc_hot ? ST_MULT : ST_OFFSET;
         end
         ST_MULT: begin
            state_in = ST_OFFSET;
         end
         ST_OFFSET: begin
            if (st.out_free) begin
               if (st.close1)               state_in = ST_CLOSE1;
               else if (st.hot || st.cold)  state_in = ST_PLACE;
               else if (st.endall)          state_in = ST_CLOSE2;
               else                         state_in = ST_IDLE;
            end
         end
         ST_CLOSE1: begin
            if (!st.rec_ok || st.out_free) state_in = ST_PLACE;
         end
         ST_PLACE: begin
            if (st.out_free) begin
               if (st.hot)         state_in = ST_SPLIT;
               else if (st.endall) state_in = ST_CLOSE2;
               else                state_in = ST_IDLE;
            end
         end
         ST_SPLIT: begin
            if (!st.split_more) state_in = st.endall ? ST_CLOSE2 : ST_IDLE;
         end
         ST_CLOSE2: begin
            if (!st.merge_open || !st.rec_ok || st.out_free) state_in = ST_TOTAL;
         end
         ST_TOTAL: begin
            if (st.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE:   cmd.load = req_valid;
         ST_CALC:   cmd.calc = 1'b1;
         ST_MULT:   cmd.mult = 1'b1;
         ST_OFFSET: cmd.offset = st.out_free;
         ST_CLOSE1: begin
            cmd.close_drop = !st.rec_ok;
            cmd.close_rec  = st.rec_ok && st.out_free;
         end
         ST_PLACE:  cmd.place = st.out_free;
         ST_SPLIT:  cmd.split = st.split_more && st.out_free;
         ST_CLOSE2: begin
            cmd.close_drop = st.merge_open && !st.rec_ok;
            cmd.close_rec  = st.merge_open && st.rec_ok && st.out_free;
         end
         ST_TOTAL:  cmd.total = st.out_free;
         default:   cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

@@ sv/hcwa_dpath.sv @@
`default_nettype none

module hcwa_dpath
   import hcwa_pkg::*;
#(
   parameter int NUM_OWNERS  = 64,
   parameter int MAX_WORKERS = 32
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   output status_type             st,
   input  wire logic [CNT_W-1:0]  req_record_count,
   input  wire logic              req_last_source,
   input  wire logic              req_last_owner,
   input  wire logic              csr_valid,
   input  wire logic              csr_ready,
   input  wire logic [CSR_W-1:0]  csr_index,
   input  wire logic [AMT_W-1:0]  csr_wdata,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [1:0]             rsp_kind,
   output logic [OWN_W-1:0]       rsp_owner,
   output logic [WRK_W-1:0]       rsp_worker,
   output logic [AMT_W-1:0]       rsp_amount,
   output logic [OWN_W-1:0]       rsp_first_owner,
   output logic [SPAN_W-1:0]      rsp_owner_span,
   output logic                   rsp_overflow,
   output logic                   rsp_last
);

   localparam int OWN_LIM = (NUM_OWNERS < 64) ? NUM_OWNERS : 64;
   localparam logic [SPAN_W-1:0] OWN_LIM_V = SPAN_W'(OWN_LIM);
   localparam logic [WRK_W-1:0]  WK_MAX    = WRK_W'(MAX_WORKERS);

   // configuration
   logic [AMT_W-1:0]  cap_reg_ff;
   logic [SPAN_W-1:0] span_lim_ff;

   // batch state
   logic [OWN_W-1:0]  oc_ff, oc_in;
   logic [AMT_W-1:0]  rt_ff, rt_in;
   logic [WRK_W-1:0]  wu_ff, wu_in;
   logic [AMT_W-1:0]  fill_ff, fill_in;
   logic [OWN_W-1:0]  mfo_ff, mfo_in;
   logic [OWN_W-1:0]  mlo_ff, mlo_in;
   logic              open_ff, open_in;
   logic              ovf_seen_ff, ovf_seen_in;

   // item working registers
   logic [CNT_W-1:0]  cnt_ff;
   logic              endsrc_ff;
   logic              endall_ff;
   logic [OWN_W-1:0]  o_ff;
   logic [AMT_W-1:0]  off_ff;
   logic [AMT_W-1:0]  t_ff;
   logic              hot_ff;
   logic              cold_ff;
   logic              close1_ff;
   logic              base_ff;
   logic [AVL_W-1:0]  avail_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [AMT_W-1:0]  rem_ff, rem_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        kind_ff, kind_in;
   logic [OWN_W-1:0]  owner_ff, owner_in;
   logic [WRK_W-1:0]  worker_ff, worker_in;
   logic [AMT_W-1:0]  amount_ff, amount_in;
   logic [OWN_W-1:0]  first_ff, first_in;
   logic [SPAN_W-1:0] span_ff, span_in;
   logic              ovf_ff, ovf_in;
   logic              last_ff, last_in;

   // item analysis
   logic [AMT_W-1:0]  cap;
   logic [AMT_W:0]    sum_c;
   logic              sat_c;
   logic [AMT_W-1:0]  t_c;
   logic              end_c;
   logic              hot_c;
   logic              cold_c;
   logic [OWN_W-1:0]  odiff_c;
   logic [SPAN_W-1:0] ospan_c;
   logic [AMT_W:0]    mfill_c;
   logic              close1_c;
   logic              wu_lt;
   logic [WRK_W-1:0]  wu1_c;
   logic              wu1_lt;
   logic              open_after_c;
   logic              close2_c;
   logic              wrap_c;
   logic              base_c;
   logic              ovf_out;
   logic              out_free;
   logic              emit;
   logic [OWN_W-1:0]  mdiff;
   logic [AMT_W-1:0]  part;
   logic [SPAN_W-1:0] wu_next7;

   assign cap     = (cap_reg_ff == '0) ? AMT_W'(1) : cap_reg_ff;
   assign sum_c   = {1'b0, rt_ff} + {{(AMT_W + 1 - CNT_W){1'b0}}, cnt_ff};
   assign sat_c   = sum_c[AMT_W];
   assign t_c     = sat_c ? '1 : sum_c[AMT_W-1:0];
   assign end_c   = endsrc_ff || endall_ff;
   assign hot_c   = end_c && (t_c >= cap);
   assign cold_c  = end_c && !hot_c && (t_c != '0);
   assign odiff_c = oc_ff - mfo_ff;
   assign ospan_c = {1'b0, odiff_c} + SPAN_W'(1);
   assign mfill_c = {1'b0, fill_ff} + {1'b0, t_c};
   assign close1_c = open_ff && (hot_c ||
                     (cold_c && ((mfill_c > {1'b0, cap}) || (ospan_c > span_lim_ff))));
   assign wu_lt   = wu_ff < WK_MAX;
   assign wu1_c   = wu_ff + WRK_W'(close1_c && wu_lt);
   assign wu1_lt  = wu1_c < WK_MAX;
   assign open_after_c = cold_c ? 1'b1 : (hot_c ? 1'b0 : open_ff);
   assign close2_c = endall_ff && open_after_c;
   assign wrap_c  = end_c && !endall_ff && (({1'b0, oc_ff} + SPAN_W'(1)) >= OWN_LIM_V);
   assign base_c  = ovf_seen_ff || sat_c || (close1_c && !wu_lt) ||
                    (close2_c && !wu1_lt) || wrap_c;

   assign ovf_out  = base_ff || (hot_ff && ({{AVL_W{1'b0}}, t_ff} > prod_ff));
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = cmd.offset || cmd.close_rec || cmd.place || cmd.split || cmd.total;
   assign mdiff    = mlo_ff - mfo_ff;
   assign part     = (rem_ff < cap) ? rem_ff : cap;
   assign wu_next7 = {1'b0, wu_ff} + SPAN_W'(1);

   always_comb begin
      st            = '0;
      st.calc_hot   = hot_c;
      st.hot        = hot_ff;
      st.cold       = cold_ff;
      st.close1     = close1_ff;
      st.endall     = endall_ff;
      st.rec_ok     = wu_lt;
      st.split_more = (rem_ff != '0) && wu_lt;
      st.merge_open = open_ff;
      st.out_free   = out_free;
   end

   // state updates and result selection
   always_comb begin
      oc_in       = oc_ff;
      rt_in       = rt_ff;
      wu_in       = wu_ff;
      fill_in     = fill_ff;
      mfo_in      = mfo_ff;
      mlo_in      = mlo_ff;
      open_in     = open_ff;
      ovf_seen_in = ovf_seen_ff;
      rem_in      = rem_ff;
      kind_in     = kind_ff;
      owner_in    = owner_ff;
      worker_in   = worker_ff;
      amount_in   = amount_ff;
      first_in    = first_ff;
      span_in     = span_ff;
      ovf_in      = ovf_ff;
      last_in     = last_ff;

      if (emit) begin
         ovf_seen_in = ovf_out;
         ovf_in      = ovf_out;
         owner_in    = '0;
         worker_in   = '0;
         amount_in   = '0;
         first_in    = '0;
         span_in     = '0;
         last_in     = 1'b0;
      end

      if (cmd.calc) begin
         rt_in = end_c ? '0 : t_c;
         if (end_c && !endall_ff) oc_in = wrap_c ? '0 : oc_ff + OWN_W'(1);
      end

      if (cmd.offset) begin
         kind_in   = KIND_OFFSET;
         owner_in  = o_ff;
         amount_in = off_ff;
         last_in   = !endall_ff && !hot_ff && !cold_ff;
      end

      if (cmd.close_rec || cmd.close_drop) begin
         fill_in = '0;
         open_in = 1'b0;
      end

      if (cmd.close_rec) begin
         kind_in   = KIND_RECORD;
         worker_in = wu_ff;
         amount_in = fill_ff;
         first_in  = mfo_ff;
         span_in   = {1'b0, mdiff} + SPAN_W'(1);
         wu_in     = wu_ff + WRK_W'(1);
      end

      if (cmd.place) begin
         kind_in   = KIND_PLACE;
         owner_in  = o_ff;
         worker_in = wu_ff;
         if (hot_ff) begin
            amount_in = '0;
            rem_in    = t_ff;
            last_in   = !endall_ff && !wu_lt;
         end else begin
            amount_in = fill_ff;
            fill_in   = fill_ff + t_ff;
            mfo_in    = open_ff ? mfo_ff : o_ff;
            mlo_in    = o_ff;
            open_in   = 1'b1;
            last_in   = !endall_ff;
         end
      end

      if (cmd.split) begin
         kind_in   = KIND_RECORD;
         worker_in = wu_ff;
         amount_in = part;
         first_in  = o_ff;
         span_in   = SPAN_W'(1);
         wu_in     = wu_ff + WRK_W'(1);
         rem_in    = rem_ff - part;
         last_in   = !endall_ff &&
                     !((rem_ff > cap) && (wu_next7 < {1'b0, WK_MAX}));
      end

      if (cmd.total) begin
         kind_in     = KIND_TOTAL;
         worker_in   = wu_ff;
         last_in     = 1'b1;
         oc_in       = '0;
         rt_in       = '0;
         wu_in       = '0;
         fill_in     = '0;
         mfo_in      = '0;
         mlo_in      = '0;
         open_in     = 1'b0;
         ovf_seen_in = 1'b0;
      end

      if (emit)          rsp_valid_in = 1'b1;
      else if (out_free) rsp_valid_in = 1'b0;
      else               rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_reg_ff   <= CAP_RESET;
         span_lim_ff  <= SPAN_RESET;
         oc_ff        <= '0;
         rt_ff        <= '0;
         wu_ff        <= '0;
         fill_ff      <= '0;
         mfo_ff       <= '0;
         mlo_ff       <= '0;
         open_ff      <= 1'b0;
         ovf_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PAGE_CAP: cap_reg_ff  <= csr_wdata;
               CSR_SPAN_LIM: span_lim_ff <= csr_wdata[SPAN_W-1:0];
               default: ;
            endcase
         end
         oc_ff        <= oc_in;
         rt_ff        <= rt_in;
         wu_ff        <= wu_in;
         fill_ff      <= fill_in;
         mfo_ff       <= mfo_in;
         mlo_ff       <= mlo_in;
         open_ff      <= open_in;
         ovf_seen_ff  <= ovf_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cnt_ff    <= req_record_count;
         endsrc_ff <= req_last_source;
         endall_ff <= req_last_owner;
      end
      if (cmd.calc) begin
         o_ff      <= oc_ff;
         off_ff    <= rt_ff;
         t_ff      <= t_c;
         hot_ff    <= hot_c;
         cold_ff   <= cold_c;
         close1_ff <= close1_c;
         base_ff   <= base_c;
         avail_ff  <= AVL_W'(WK_MAX - wu1_c);
      end
      if (cmd.mult) begin
         prod_ff <= PROD_W'(cap) * PROD_W'(avail_ff);
      end
      rem_ff    <= rem_in;
      kind_ff   <= kind_in;
      owner_ff  <= owner_in;
      worker_ff <= worker_in;
      amount_ff <= amount_in;
      first_ff  <= first_in;
      span_ff   <= span_in;
      ovf_ff    <= ovf_in;
      last_ff   <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_owner       = owner_ff;
   assign rsp_worker      = worker_ff;
   assign rsp_amount      = amount_ff;
   assign rsp_first_owner = first_ff;
   assign rsp_owner_span  = span_ff;
   assign rsp_overflow    = ovf_ff;
   assign rsp_last        = last_ff;

endmodule

`default_nettype wire

@@ sv/hot_cold_worker_assigner_top.sv @@
// Hot/cold worker assigner. Record counts arrive owner by owner, source by source,
// one count per request beat; each beat returns the source's offset within its owner,
// and the beat that closes an owner (last_source or last_owner) places it if nonempty:
// an owner whose total reaches page_capacity closes any open merged worker and gets
// split workers of up to page_capacity records each, while smaller owners share a merged
// worker bounded by page_capacity records and span_limit owners. The last_owner beat
// flushes the merge, reports the worker count and clears the batch. Every response beat
// carries the batch overflow flag as it stands once the whole request is processed, and
// last marks the final response beat of a request. One request is worked at a time:
// a count that does not close an owner is accepted, analysed and answered with its offset
// beat. Closing a non-empty owner adds a placement beat and, when a merge must be closed
// first, a close step whether its record is sent or dropped. A hot owner also adds a
// multiply step to settle the overflow flag up front, a step per split worker and
// a final step to leave the split loop. The final owner adds a merge flush step (taken
// even when nothing is open) and the total beat. Rate is set by this controller sequence
// plus any response-side stall. The response register lets a new request be accepted
// while the last beat still waits. Configuration (csr_index 0: page_capacity,
// 1: span_limit) must be written only while idle; the block does not enforce this.

`default_nettype none

module hot_cold_worker_assigner_top
   import hcwa_pkg::*;
#(
   parameter int NUM_OWNERS  = 64,
   parameter int MAX_WORKERS = 32
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [CNT_W-1:0]  req_record_count,
   input  wire logic              req_last_source,
   input  wire logic              req_last_owner,
   // response channel
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [1:0]             rsp_kind,
   output logic [OWN_W-1:0]       rsp_owner,
   output logic [WRK_W-1:0]       rsp_worker,
   output logic [AMT_W-1:0]       rsp_amount,
   output logic [OWN_W-1:0]       rsp_first_owner,
   output logic [SPAN_W-1:0]      rsp_owner_span,
   output logic                   rsp_overflow,
   output logic                   rsp_last,
   // configuration write channel
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CSR_W-1:0]  csr_index,
   input  wire logic [AMT_W-1:0]  csr_wdata
);

   cmd_type    cmd;
   status_type st;

   // registers take a write in any cycle; writes must only be issued while idle, not enforced here
   assign csr_ready = 1'b1;

   // sequence one request beat through analyse, place and record steps
   hcwa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   // hold batch state, config and the response register
   hcwa_dpath #(
      .NUM_OWNERS  (NUM_OWNERS),
      .MAX_WORKERS (MAX_WORKERS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_record_count (req_record_count),
      .req_last_source  (req_last_source),
      .req_last_owner   (req_last_owner),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_owner        (rsp_owner),
      .rsp_worker       (rsp_worker),
      .rsp_amount       (rsp_amount),
      .rsp_first_owner  (rsp_first_owner),
      .rsp_owner_span   (rsp_owner_span),
      .rsp_overflow     (rsp_overflow),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

@@ dv/hcwa_plan_pkg.sv @@
package hcwa_plan_pkg;

   import hcwa_pkg::*;

   localparam int NUM_OWNERS  = 64;
   localparam int MAX_WORKERS = 32;
   localparam int OWNER_TOP   = (1 << OWN_W) - 1;
   localparam logic [AMT_W-1:0] AMT_CEILING = '1;
   // index with no register behind it; a write there changes nothing
   localparam logic [CSR_W-1:0] CSR_SPARE = 2'd2;

   typedef struct packed {
      kind_type          kind;
      logic [OWN_W-1:0]  owner;
      logic [WRK_W-1:0]  worker;
      logic [AMT_W-1:0]  amount;
      logic [OWN_W-1:0]  first_owner;
      logic [SPAN_W-1:0] owner_span;
      logic              overflow;
      logic              last;
   } plan_beat_type;

   class worker_plan_checker;
      logic [AMT_W-1:0]  page_cap;
      logic [SPAN_W-1:0] merge_span_lim;

      logic [OWN_W-1:0]  owner_idx;
      logic [AMT_W-1:0]  owner_sum;
      logic [WRK_W-1:0]  workers_taken;
      logic [AMT_W-1:0]  merge_records;
      logic [OWN_W-1:0]  merge_head;
      logic [OWN_W-1:0]  merge_tail;
      logic              merge_live;
      logic              batch_overflow;

      plan_beat_type     staged[$];
      plan_beat_type     pending_beats[$];
      int                mismatches;
      int                beats_checked;

      function new();
         page_cap       = CAP_RESET;
         merge_span_lim = SPAN_RESET;
         mismatches     = 0;
         beats_checked  = 0;
         clear_batch();
      endfunction

      function void clear_batch();
         owner_idx      = '0;
         owner_sum      = '0;
         workers_taken  = '0;
         merge_records  = '0;
         merge_head     = '0;
         merge_tail     = '0;
         merge_live     = 1'b0;
         batch_overflow = 1'b0;
      endfunction

      function void set_register(logic [CSR_W-1:0] idx, logic [AMT_W-1:0] data);
         if (idx == CSR_PAGE_CAP) begin
            page_cap = data;
         end else if (idx == CSR_SPAN_LIM) begin
            merge_span_lim = data[SPAN_W-1:0];
         end
      endfunction

      function plan_beat_type make_beat(kind_type kind, logic [OWN_W-1:0] owner,
                                        logic [WRK_W-1:0] worker, logic [AMT_W-1:0] amount,
                                        logic [OWN_W-1:0] first_owner,
                                        logic [SPAN_W-1:0] owner_span);
         plan_beat_type b;
         b.kind        = kind;
         b.owner       = owner;
         b.worker      = worker;
         b.amount      = amount;
         b.first_owner = first_owner;
         b.owner_span  = owner_span;
         b.overflow    = 1'b0;
         b.last        = 1'b0;
         return b;
      endfunction

      // past the worker budget a record is dropped and the batch flagged
      function void take_worker(logic [OWN_W-1:0] first_owner, logic [SPAN_W-1:0] owner_span,
                                logic [AMT_W-1:0] amount);
         if (workers_taken < MAX_WORKERS) begin
            staged.push_back(make_beat(KIND_RECORD, '0, workers_taken, amount,
                                       first_owner, owner_span));
            workers_taken++;
         end else begin
            batch_overflow = 1'b1;
         end
      endfunction

      function void close_merge();
         logic [OWN_W-1:0] reach;
         if (merge_live) begin
            reach = merge_tail - merge_head;
            take_worker(merge_head, {1'b0, reach} + 1'b1, merge_records);
            merge_records = '0;
            merge_live    = 1'b0;
         end
      endfunction

      // work out every beat one accepted count causes and queue them
      function void note_count(logic [CNT_W-1:0] cnt, logic end_src, logic end_all);
         int unsigned      cap;
         int unsigned      sum;
         int unsigned      rest;
         int unsigned      part;
         int unsigned      reach;
         logic [OWN_W-1:0] o;
         logic [OWN_W-1:0] gap_owners;

         staged.delete();
         cap = (page_cap == 0) ? 1 : page_cap;
         o   = owner_idx;

         staged.push_back(make_beat(KIND_OFFSET, o, '0, owner_sum, '0, '0));
         sum = owner_sum + cnt;
         if (sum > AMT_CEILING) begin
            owner_sum      = AMT_CEILING;
            batch_overflow = 1'b1;
         end else begin
            owner_sum = AMT_W'(sum);
         end

         if (end_src || end_all) begin
            sum = owner_sum;
            if (sum >= cap) begin
               close_merge();
               staged.push_back(make_beat(KIND_PLACE, o, workers_taken, '0, '0, '0));
               rest = sum;
               while (rest > 0) begin
                  if (workers_taken >= MAX_WORKERS) begin
                     batch_overflow = 1'b1;
                     rest = 0;
                  end else begin
                     part = (rest < cap) ? rest : cap;
                     take_worker(o, SPAN_W'(1), AMT_W'(part));
                     rest -= part;
                  end
               end
            end else if (sum > 0) begin
               gap_owners = o - merge_head;
               reach      = gap_owners + 1;
               if (merge_live && (merge_records + sum > cap || reach > merge_span_lim))
                  close_merge();
               if (!merge_live) begin
                  merge_head    = o;
                  merge_records = '0;
                  merge_live    = 1'b1;
               end
               staged.push_back(make_beat(KIND_PLACE, o, workers_taken, merge_records,
                                          '0, '0));
               merge_records = merge_records + AMT_W'(sum);
               merge_tail    = o;
            end
            owner_sum = '0;
            if (end_all) begin
               close_merge();
               staged.push_back(make_beat(KIND_TOTAL, '0, workers_taken, '0, '0, '0));
            end else if (o + 1 >= NUM_OWNERS || o + 1 > OWNER_TOP) begin
               owner_idx      = '0;
               batch_overflow = 1'b1;
            end else begin
               owner_idx = o + OWN_W'(1);
            end
         end

         foreach (staged[i]) begin
            staged[i].overflow = batch_overflow;
            staged[i].last     = (i == staged.size() - 1);
            pending_beats.push_back(staged[i]);
         end
         if (end_all)
            clear_batch();
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("MISMATCH %s", msg);
      endtask

      task compare_field(string name, logic [31:0] want, logic [31:0] seen);
         if (seen !== want)
            report_mismatch($sformatf("beat %0d %s: expected %0d, got %0d",
                                      beats_checked, name, want, seen));
      endtask

      task check_beat(plan_beat_type seen);
         plan_beat_type want;
         beats_checked++;
         if (pending_beats.size() == 0) begin
            report_mismatch($sformatf("beat %0d arrived with nothing outstanding (kind %0d)",
                                      beats_checked, seen.kind));
            return;
         end
         want = pending_beats.pop_front();
         compare_field("kind",        want.kind,        seen.kind);
         compare_field("owner",       want.owner,       seen.owner);
         compare_field("worker",      want.worker,      seen.worker);
         compare_field("amount",      want.amount,      seen.amount);
         compare_field("first_owner", want.first_owner, seen.first_owner);
         compare_field("owner_span",  want.owner_span,  seen.owner_span);
         compare_field("overflow",    want.overflow,    seen.overflow);
         compare_field("last",        want.last,        seen.last);
      endtask
   endclass

endpackage

@@ dv/tb.sv @@
module tb
   import hcwa_pkg::*;
   import hcwa_plan_pkg::*;
();

   // run length guard, well clear of the slowest legal run
   localparam int RUN_LIMIT_CYCLES = 600000;
   // cycles allowed after the last expected beat before the verdict
   localparam int SETTLE_CYCLES    = 40;
   // one long receiver hold-off so the block backs up into the request side
   localparam int HOLD_AFTER_BEATS = 180;
   localparam int HOLD_CYCLES      = 300;
   localparam int PHASE_QUOTA      = 52;

   logic              clock = 1'b0;
   logic              reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [CNT_W-1:0]  req_record_count = '0;
   logic              req_last_source = 1'b0;
   logic              req_last_owner = 1'b0;

   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_kind;
   logic [OWN_W-1:0]  rsp_owner;
   logic [WRK_W-1:0]  rsp_worker;
   logic [AMT_W-1:0]  rsp_amount;
   logic [OWN_W-1:0]  rsp_first_owner;
   logic [SPAN_W-1:0] rsp_owner_span;
   logic              rsp_overflow;
   logic              rsp_last;

   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_W-1:0]  csr_index = '0;
   logic [AMT_W-1:0]  csr_wdata = '0;

   worker_plan_checker plan;

   int                counts_sent = 0;
   int                beats_taken = 0;
   int                batches_run = 0;
   int                settings_used = 1;
   int unsigned       cur_cap = CAP_RESET;

   always #5 clock = ~clock;

   hot_cold_worker_assigner_top #(
      .NUM_OWNERS  (NUM_OWNERS),
      .MAX_WORKERS (MAX_WORKERS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_record_count(req_record_count),
      .req_last_source (req_last_source),
      .req_last_owner  (req_last_owner),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_owner       (rsp_owner),
      .rsp_worker      (rsp_worker),
      .rsp_amount      (rsp_amount),
      .rsp_first_owner (rsp_first_owner),
      .rsp_owner_span  (rsp_owner_span),
      .rsp_overflow    (rsp_overflow),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // Offer one count beat and hold it until the block takes it. The gap before it
   // is drawn per beat; every 80 beats a run of 20 goes back to back. valid is only
   // dropped when a gap follows, so it never gets two updates in one time step.
   task automatic send_count(input logic [CNT_W-1:0] cnt, input logic end_src,
                             input logic end_all);
      int gap;
      gap = (counts_sent % 80 < 20) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_record_count <= cnt;
      req_last_source  <= end_src;
      req_last_owner   <= end_all;
      do @(posedge clock); while (req_stall !== 1'b0);
      plan.note_count(cnt, end_src, end_all);
      counts_sent++;
   endtask

   // Hold the write until it is taken. valid stays up between back-to-back writes;
   // the caller drops it once the group is done.
   task automatic csr_write(input logic [CSR_W-1:0] idx, input logic [AMT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      plan.set_register(idx, data);
   endtask

   // Span limit sits in the low bits; fill the rest with noise the block must ignore.
   task automatic program_regs(input logic [AMT_W-1:0] cap, input logic [SPAN_W-1:0] span,
                               input bit touch_spare);
      logic [AMT_W-1:0] span_word;
      span_word = AMT_W'($urandom_range(0, 1048575));
      span_word[SPAN_W-1:0] = span;
      csr_write(CSR_PAGE_CAP, cap);
      csr_write(CSR_SPAN_LIM, span_word);
      if (touch_spare)
         csr_write(CSR_SPARE, AMT_W'($urandom_range(0, 1048575)));
      csr_valid <= 1'b0;
      cur_cap = (cap == 0) ? 1 : cap;
      settings_used++;
   endtask

   // Stop offering and wait for every outstanding beat: the block is idle after that.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (plan.pending_beats.size() != 0) @(posedge clock);
   endtask

   // Mix of empty, tiny, full-scale and capacity-relative counts so that owners land
   // both hot and cold under whatever page capacity is programmed.
   function automatic logic [CNT_W-1:0] draw_count();
      int unsigned top;
      top = (cur_cap > 65535) ? 65535 : cur_cap;
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return CNT_W'($urandom_range(1, 255));
         4:       return CNT_W'($urandom_range(0, top));
         5:       return CNT_W'($urandom_range(0, 65535));
         default: return CNT_W'($urandom_range(0, top / 3 + 1));
      endcase
   endfunction

   // Mostly well-formed batches: owners of a few sources each, closed by last_owner.
   // A long batch of single-source owners runs the owner index past its end. A
   // ragged batch scatters the end flags at random, leaving state open across batches.
   task automatic run_batches(input int quota, input bit force_long);
      int   first_count;
      int   owners;
      int   srcs;
      int   o;
      int   s;
      bit   long_run;
      bit   ragged;
      logic ls;
      logic lo;
      first_count = counts_sent;
      while (counts_sent - first_count < quota || force_long) begin
         long_run   = force_long || ($urandom_range(0, 39) == 0);
         force_long = 1'b0;
         ragged     = ($urandom_range(0, 7) == 0);
         owners     = long_run ? $urandom_range(65, 68) : $urandom_range(1, 10);
         for (o = 0; o < owners; o++) begin
            srcs = long_run ? 1 : $urandom_range(1, 5);
            for (s = 0; s < srcs; s++) begin
               ls = (s == srcs - 1);
               lo = ls && (o == owners - 1);
               if (ragged) begin
                  ls = 1'($urandom_range(0, 1));
                  lo = ($urandom_range(0, 11) == 0);
               end
               send_count(draw_count(), ls, lo);
            end
         end
         batches_run++;
      end
   endtask

   // Stimulus and verdict.
   initial begin
      int i;
      plan = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed, under reset register values (capacity 4096, span 64).
      send_count(16'd0, 1'b1, 1'b0);         // empty owner: offset only
      send_count(16'd100, 1'b0, 1'b0);
      send_count(16'd200, 1'b1, 1'b0);       // cold owner opens a merge
      send_count(16'd3000, 1'b1, 1'b0);      // cold owner joins it
      send_count(16'd900, 1'b1, 1'b0);       // would overfill: close and reopen
      send_count(16'd4096, 1'b1, 1'b0);      // hot at exactly capacity
      send_count(16'hFFFF, 1'b1, 1'b0);      // hot, sixteen split workers
      send_count(16'hFFFF, 1'b0, 1'b1);      // final owner without last_source,
                                             // runs out of workers
      // seventeen full counts saturate the owner total, then the batch closes
      for (i = 0; i < 16; i++)
         send_count(16'hFFFF, 1'b0, 1'b0);
      send_count(16'hFFFF, 1'b0, 1'b1);
      batches_run += 2;

      // Random phases, each under its own register setting.
      drain_results();
      program_regs(20'hFFFFF, 7'd1, 1'b0);   // widest capacity, one owner per merge
      run_batches(PHASE_QUOTA, 1'b0);

      drain_results();
      program_regs(20'd0, 7'd64, 1'b1);      // zero capacity behaves as one
      run_batches(PHASE_QUOTA, 1'b0);

      drain_results();
      program_regs(20'd5000, 7'd0, 1'b0);    // zero span: each cold owner closes any open merge first
      run_batches(PHASE_QUOTA, 1'b0);

      drain_results();
      program_regs(AMT_W'($urandom_range(100, 5000)), SPAN_W'($urandom_range(2, 10)), 1'b0);
      run_batches(PHASE_QUOTA, 1'b1);        // forces a long batch, which wraps the owner index unless drawn ragged

      drain_results();
      program_regs(20'd1, 7'd127, 1'b0);     // smallest capacity, widest span field
      run_batches(PHASE_QUOTA, 1'b0);

      drain_results();
      program_regs(AMT_W'($urandom_range(1, 65535)), SPAN_W'($urandom_range(0, 64)), 1'b0);
      run_batches(PHASE_QUOTA, 1'b0);

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d counts in %0d batches under %0d register settings,",
               counts_sent, batches_run, settings_used);
      $display("with %0d result beats checked and %0d mismatches.",
               plan.beats_checked, plan.mismatches);
      if (plan.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Result side: draw a stall before each beat, hold it off once for a long stretch,
   // then take the beat and check it against the oldest expectation.
   initial begin
      int            pause;
      plan_beat_type seen;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         pause = (beats_taken % 100 < 25) ? 0 : $urandom_range(0, 8);
         if (beats_taken == HOLD_AFTER_BEATS)
            pause = HOLD_CYCLES;
         if (pause > 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         seen.kind        = kind_type'(rsp_kind);
         seen.owner       = rsp_owner;
         seen.worker      = rsp_worker;
         seen.amount      = rsp_amount;
         seen.first_owner = rsp_first_owner;
         seen.owner_span  = rsp_owner_span;
         seen.overflow    = rsp_overflow;
         seen.last        = rsp_last;
         plan.check_beat(seen);
         beats_taken++;
      end
   end

   // Hard stop should the block hang.
   initial begin
      repeat (RUN_LIMIT_CYCLES) @(posedge clock);
      $display("Timed out after %0d cycles", RUN_LIMIT_CYCLES);
      $display("Regression FAIL");
      $finish;
   end

endmodule
